[src/gzip_stored_envelope_framer_macros.svh]
// Assertion macros used by the checker file.
`ifndef GZIP_STORED_ENVELOPE_FRAMER_MACROS_SVH
`define GZIP_STORED_ENVELOPE_FRAMER_MACROS_SVH

// Same-cycle implication.
`define GSE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gse assertion failed");

// Next-cycle implication.
`define GSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gse assertion failed");

`endif

[src/gse_pkg.sv]
package gse_pkg;

   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CHUNK_W    = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MEMBER_LENGTH = 2'd0,
      REG_STORED_MODE   = 2'd1,
      REG_TRAILER_CRC   = 2'd2,
      REG_TRAILER_SIZE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0] member_length;
      logic        stored_mode;
      logic [31:0] trailer_crc;
      logic [31:0] trailer_size;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       source_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       envelope_done;
      logic       short_error;
   } rsp_type;

   // One classified transaction handed from front to back.
   typedef struct packed {
      logic               err;
      logic               hdr;
      logic               blk;
      logic               blk_final;
      logic [CHUNK_W-1:0] chunk;
      logic [7:0]         data;
      logic               trl;
   } desc_type;

endpackage

[src/gse_front.sv]
module gse_front #(
   parameter int BLOCK_MAX = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  gse_pkg::cfg_type  cfg,
   input  logic              req_valid,
   input  gse_pkg::req_type  req_data,
   output logic              req_stall,
   output logic              push,
   output gse_pkg::desc_type push_desc,
   input  logic              q_full
);
   import gse_pkg::*;

   localparam int BL_W = $clog2(BLOCK_MAX + 1);
   localparam logic [32:0] BLOCK_MAX_W = 33'(BLOCK_MAX);

   logic [31:0]     bytes_seen_ff, bytes_seen_in;
   logic [BL_W-1:0] blk_left_ff, blk_left_in;
   logic            halted_ff, halted_in;

   logic [32:0]     rem;
   logic            rem_one;
   logic            err;
   logic            big;
   logic            need_blk;
   logic [BL_W-1:0] chunk;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full && !halted_ff;

   always_comb begin
      rem      = {1'b0, cfg.member_length} - {1'b0, bytes_seen_ff};
      rem_one  = (rem == 33'd1);
      err      = rem[32] || (rem == 33'd0) || (rem_one != req_data.source_end);
      big      = (rem > BLOCK_MAX_W);
      chunk    = big ? BL_W'(BLOCK_MAX) : rem[BL_W-1:0];
      need_blk = cfg.stored_mode && (blk_left_ff == '0);

      push_desc.err       = err;
      push_desc.hdr       = (bytes_seen_ff == 32'd0);
      push_desc.blk       = need_blk;
      push_desc.blk_final = !big;
      push_desc.chunk     = CHUNK_W'(chunk);
      push_desc.data      = req_data.data_byte;
      push_desc.trl       = rem_one;
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      blk_left_in   = blk_left_ff;
      halted_in     = halted_ff;
      if (push) begin
         if (err) begin
            halted_in = 1'b1;
         end else begin
            bytes_seen_in = bytes_seen_ff + 32'd1;
            if (cfg.stored_mode) begin
               blk_left_in = (need_blk ? chunk : blk_left_ff) - BL_W'(1);
            end
            halted_in = rem_one;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         blk_left_ff   <= '0;
         halted_ff     <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         blk_left_ff   <= blk_left_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

[src/gse_queue.sv]
module gse_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gse_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output gse_pkg::desc_type pop_desc
);
   import gse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign q_valid  = (count_ff != '0);
   assign pop_desc = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/gse_back.sv]
module gse_back (
   input  logic              clock,
   input  logic              reset,
   input  gse_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  gse_pkg::desc_type q_desc,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gse_pkg::rsp_type  rsp_data
);
   import gse_pkg::*;

   // Byte slots: gzip header, stored-block header, member byte, trailer.
   localparam int SLOT_W = 5;
   localparam logic [SLOT_W-1:0] SLOT_HDR      = 5'd0;
   localparam logic [SLOT_W-1:0] SLOT_HDR_LAST = 5'd9;
   localparam logic [SLOT_W-1:0] SLOT_BLK      = 5'd10;
   localparam logic [SLOT_W-1:0] SLOT_DATA     = 5'd15;
   localparam logic [SLOT_W-1:0] SLOT_LAST     = 5'd23;

   localparam logic [7:0] GZ_ID1     = 8'h1F;
   localparam logic [7:0] GZ_ID2     = 8'h8B;
   localparam logic [7:0] GZ_CM_DEFL = 8'h08;
   localparam logic [7:0] GZ_OS_UNK  = 8'hFF;

   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [SLOT_W-1:0] first_slot, cur, nxt;
   logic              load, last;
   logic [7:0]        slot_byte;
   logic [CHUNK_W-1:0] inv;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      first_slot = q_desc.hdr ? SLOT_HDR : (q_desc.blk ? SLOT_BLK : SLOT_DATA);
      cur        = busy_ff ? slot_ff : first_slot;
      load       = q_valid && (!rsp_valid_ff || !rsp_stall);
      last       = q_desc.err || ((cur == SLOT_DATA) && !q_desc.trl) || (cur == SLOT_LAST);
      nxt        = (cur == SLOT_HDR_LAST) ? (q_desc.blk ? SLOT_BLK : SLOT_DATA)
                                          : cur + SLOT_W'(1);
      inv        = ~q_desc.chunk;
      case (cur) inside
         5'd0:          slot_byte = GZ_ID1;
         5'd1:          slot_byte = GZ_ID2;
         5'd2:          slot_byte = GZ_CM_DEFL;
         [5'd3:5'd8]:   slot_byte = 8'h00;
         5'd9:          slot_byte = GZ_OS_UNK;
         5'd10:         slot_byte = {7'd0, q_desc.blk_final};
         5'd11:         slot_byte = q_desc.chunk[7:0];
         5'd12:         slot_byte = q_desc.chunk[15:8];
         5'd13:         slot_byte = inv[7:0];
         5'd14:         slot_byte = inv[15:8];
         5'd15:         slot_byte = q_desc.data;
         5'd16:         slot_byte = cfg.trailer_crc[7:0];
         5'd17:         slot_byte = cfg.trailer_crc[15:8];
         5'd18:         slot_byte = cfg.trailer_crc[23:16];
         5'd19:         slot_byte = cfg.trailer_crc[31:24];
         5'd20:         slot_byte = cfg.trailer_size[7:0];
         5'd21:         slot_byte = cfg.trailer_size[15:8];
         5'd22:         slot_byte = cfg.trailer_size[23:16];
         5'd23:         slot_byte = cfg.trailer_size[31:24];
         default:       slot_byte = 8'h00;
      endcase
   end

   always_comb begin
      pop          = load && last;
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         busy_in                   = !last;
         slot_in                   = nxt;
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_byte      = q_desc.err ? 8'h00 : slot_byte;
         rsp_data_in.run_last      = last;
         rsp_data_in.envelope_done = !q_desc.err && (cur == SLOT_LAST);
         rsp_data_in.short_error   = q_desc.err;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      slot_ff     <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/gzip_stored_envelope_framer.sv]
// gzip envelope framer. Each accepted member byte is checked against member_length and
// classified combinationally, then queued; the emitter sends one envelope byte per
// cycle from its output register while rsp_stall is low. An item yields its member
// byte, plus the 10-byte gzip header on the first byte, plus a 5-byte stored-block
// header in stored mode where a new block opens, plus the 8-byte CRC and size trailer
// on the last byte; a length error yields a single short_error byte and halts the
// block until reset. With rsp_stall low the pass-through rate is one byte per cycle,
// and the first output byte of an item goes through the queue and the output register
// to rsp_data. The user must write registers only while idle; this is not enforced.
module gzip_stored_envelope_framer #(
   parameter int BLOCK_MAX = 65535
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gse_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gse_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gse_pkg::rsp_type                  rsp_data
);
   import gse_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push, q_full, pop, q_valid;
   desc_type push_desc, q_desc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_MEMBER_LENGTH: cfg_in.member_length = csr_wdata;
            REG_STORED_MODE:   cfg_in.stored_mode   = csr_wdata[0];
            REG_TRAILER_CRC:   cfg_in.trailer_crc   = csr_wdata;
            REG_TRAILER_SIZE:  cfg_in.trailer_size  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.member_length <= 32'd1;
         cfg_ff.stored_mode   <= 1'b0;
         cfg_ff.trailer_crc   <= 32'd0;
         cfg_ff.trailer_size  <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gse_front #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .push      (push),
      .push_desc (push_desc),
      .q_full    (q_full)
   );

   gse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .pop_desc  (q_desc)
   );

   gse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_desc    (q_desc),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[src/gse_checker.sv]
`include "gzip_stored_envelope_framer_macros.svh"

module gse_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gse_pkg::rsp_type rsp_data
);
   import gse_pkg::*;

   logic ended_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall &&
                   (rsp_data.envelope_done || rsp_data.short_error)) begin
         ended_ff <= 1'b1;
      end
   end

   `GSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `GSE_ASSERT_NOW(a_err_shape, clock, reset, rsp_valid && rsp_data.short_error, rsp_data.run_last && !rsp_data.envelope_done && rsp_data.out_byte == 8'h00)
   `GSE_ASSERT_NOW(a_done_last, clock, reset, rsp_valid && rsp_data.envelope_done, rsp_data.run_last && !rsp_data.short_error)
   `GSE_ASSERT_NOW(a_quiet_after_end, clock, reset, ended_ff, !rsp_valid)

endmodule

bind gzip_stored_envelope_framer gse_checker u_gse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/gzip_stored_envelope_framer_tb.sv]
`timescale 1ns / 100ps

module gzip_stored_envelope_framer_tb;
   import gse_pkg::*;

   localparam int          BLOCK_MAX     = 65535;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          TARGET_ITEMS  = 104;
   localparam int          SQUEEZE_LEN   = 150;
   localparam logic [79:0] GZIP_HEADER   = 80'h1F8B08000000000000FF;
   localparam logic [7:0]  FINAL_BLOCK   = 8'h01;
   localparam logic [7:0]  OPEN_BLOCK    = 8'h00;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;

   // shadow registers and framer state
   cfg_type     csr_shadow;
   logic [31:0] seen_count = '0;
   logic [16:0] block_remaining = '0;
   bit          framer_halted = 1'b0;

   req_type     member_bytes_pending[$];
   rsp_type     envelope_bytes_due[$];

   int unsigned offered_total = 0;
   int unsigned accepted_total = 0;
   int unsigned checked_total = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned hold_gap = 0;
   int unsigned squeeze_left = 0;
   bit          offer_next;
   bit          calm = 1'b0;
   bit          squeeze_armed = 1'b0;
   bit          squeeze_spent = 1'b0;

   gzip_stored_envelope_framer #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 2))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Expected envelope bytes for one member byte transaction.
   task automatic frame_member_byte(input req_type member);
      logic [32:0] next_count;
      logic [32:0] promised;
      logic [32:0] left_total;
      logic [15:0] chunk;
      logic [15:0] chunk_inv;
      logic [7:0]  bytes_out[$];
      logic        closing;
      rsp_type     beat;
      int          i;
      if (framer_halted) return;
      next_count = {1'b0, seen_count} + 33'd1;
      promised = {1'b0, csr_shadow.member_length};
      if (next_count > promised || (next_count == promised && !member.source_end)
          || (next_count < promised && member.source_end)) begin
         beat.out_byte = 8'h00;
         beat.run_last = 1'b1;
         beat.envelope_done = 1'b0;
         beat.short_error = 1'b1;
         envelope_bytes_due.push_back(beat);
         framer_halted = 1'b1;
         return;
      end
      if (seen_count == 0) begin
         for (i = 9; i >= 0; i--) bytes_out.push_back(GZIP_HEADER[i*8 +: 8]);
      end
      if (csr_shadow.stored_mode) begin
         if (block_remaining == 0) begin
            left_total = promised - {1'b0, seen_count};
            chunk = (left_total > BLOCK_MAX) ? 16'(BLOCK_MAX) : left_total[15:0];
            chunk_inv = ~chunk;
            bytes_out.push_back((left_total > BLOCK_MAX) ? OPEN_BLOCK : FINAL_BLOCK);
            bytes_out.push_back(chunk[7:0]);
            bytes_out.push_back(chunk[15:8]);
            bytes_out.push_back(chunk_inv[7:0]);
            bytes_out.push_back(chunk_inv[15:8]);
            block_remaining = {1'b0, chunk};
         end
         block_remaining = block_remaining - 17'd1;
      end
      bytes_out.push_back(member.data_byte);
      seen_count = next_count[31:0];
      closing = (next_count == promised);
      if (closing) begin
         for (i = 0; i < 4; i++) bytes_out.push_back(csr_shadow.trailer_crc[8*i +: 8]);
         for (i = 0; i < 4; i++) bytes_out.push_back(csr_shadow.trailer_size[8*i +: 8]);
         framer_halted = 1'b1;
      end
      for (i = 0; i < bytes_out.size(); i++) begin
         beat.out_byte = bytes_out[i];
         beat.run_last = (i == bytes_out.size() - 1);
         beat.envelope_done = closing && beat.run_last;
         beat.short_error = 1'b0;
         envelope_bytes_due.push_back(beat);
      end
   endtask

   task automatic check_envelope_byte(input rsp_type got);
      rsp_type want;
      checked_total++;
      if (envelope_bytes_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("byte %0d: no transaction expected, got %h", checked_total, got);
      end else begin
         want = envelope_bytes_due.pop_front();
         if (got.out_byte !== want.out_byte || got.run_last !== want.run_last
             || got.envelope_done !== want.envelope_done
             || got.short_error !== want.short_error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("byte %0d: expected %h last=%b done=%b err=%b, got %h last=%b done=%b err=%b",
                        checked_total, want.out_byte, want.run_last, want.envelope_done,
                        want.short_error, got.out_byte, got.run_last, got.envelope_done,
                        got.short_error);
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer_next = req_valid;
         if (req_valid && !req_stall) begin
            frame_member_byte(req_data);
            accepted_total++;
            offer_next = 1'b0;
         end
         if (!offer_next) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (member_bytes_pending.size() != 0) begin
               req_data <= member_bytes_pending.pop_front();
               offer_next = 1'b1;
               send_gap = pick_gap();
            end
         end
         req_valid <= offer_next;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_envelope_byte(rsp_data);
         if (hold_gap != 0) hold_gap--;
         else hold_gap = pick_gap();
         rsp_stall <= (hold_gap != 0) || (squeeze_left != 0);
      end
   end

   // long receiver hold-off, once per run
   always @(posedge clock) begin
      if (reset) begin
         squeeze_left <= 0;
      end else if (squeeze_armed && !squeeze_spent) begin
         squeeze_left <= SQUEEZE_LEN;
         squeeze_spent <= 1'b1;
      end else if (squeeze_left != 0) begin
         squeeze_left <= squeeze_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("gzip_stored_envelope_framer: mismatch");
         $finish;
      end
   end

   task automatic set_reg(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_MEMBER_LENGTH: csr_shadow.member_length = value;
         REG_STORED_MODE:   csr_shadow.stored_mode = value[0];
         REG_TRAILER_CRC:   csr_shadow.trailer_crc = value;
         REG_TRAILER_SIZE:  csr_shadow.trailer_size = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      req_type member;
      member.data_byte = data;
      member.source_end = last;
      member_bytes_pending.push_back(member);
      offered_total++;
   endtask

   task automatic send_bytes(input int unsigned count, input logic end_on_last);
      int unsigned i;
      for (i = 0; i < count; i++)
         send_byte(8'($urandom_range(0, 255)), end_on_last && (i == count - 1));
   endtask

   task automatic settle();
      while (accepted_total != offered_total || envelope_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned k;
      int unsigned roll;
      csr_shadow.member_length = 32'd1;
      csr_shadow.stored_mode = 1'b0;
      csr_shadow.trailer_crc = '0;
      csr_shadow.trailer_size = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // small first stored block, finished after widening the length, then passthrough
      set_reg(REG_MEMBER_LENGTH, 32'd3);
      set_reg(REG_STORED_MODE, 32'd1);
      set_reg(REG_TRAILER_CRC, 32'hFFFF_FFFF);
      set_reg(REG_TRAILER_SIZE, 32'h0000_0000);
      send_byte(8'h00, 1'b0);
      settle();
      set_reg(REG_MEMBER_LENGTH, 32'hFFFF_FFFF);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      settle();
      set_reg(REG_STORED_MODE, 32'd0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      settle();

      while (offered_total < TARGET_ITEMS) begin
         calm <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) set_reg(REG_TRAILER_CRC, pick_word());
         if ($urandom_range(0, 2) == 0) set_reg(REG_TRAILER_SIZE, pick_word());
         if (squeeze_armed && $urandom_range(0, 3) != 0) begin
            // open a short block, then widen the length so the block runs out mid-stream
            k = $urandom_range(2, 6);
            set_reg(REG_STORED_MODE, 32'd1);
            set_reg(REG_MEMBER_LENGTH, seen_count + k);
            send_bytes(1, 1'b0);
            settle();
            set_reg(REG_MEMBER_LENGTH, seen_count + $urandom_range(100, 60000));
            send_bytes(block_remaining, 1'b0);
         end else begin
            set_reg(REG_STORED_MODE, 32'd0);
            set_reg(REG_MEMBER_LENGTH, $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                            : seen_count + $urandom_range(40, 5000));
            send_bytes(squeeze_armed ? $urandom_range(3, 25) : 25, 1'b0);
            squeeze_armed <= 1'b1;
         end
         settle();
      end

      calm <= 1'b0;
      if ($urandom_range(0, 1)) begin
         // block longer than BLOCK_MAX: non-final header
         set_reg(REG_STORED_MODE, 32'd1);
         set_reg(REG_MEMBER_LENGTH, 32'hFFFF_FFFF);
         send_bytes(2, 1'b0);
         settle();
      end
      set_reg(REG_STORED_MODE, $urandom_range(0, 1));
      set_reg(REG_TRAILER_CRC, pick_word());
      set_reg(REG_TRAILER_SIZE, pick_word());
      roll = $urandom_range(0, 7);
      case (roll)
         0, 1, 2, 3: begin
            k = $urandom_range(1, 3);
            set_reg(REG_MEMBER_LENGTH, seen_count + k);
            send_bytes(k, 1'b1);
         end
         4: begin
            // source ends early
            set_reg(REG_MEMBER_LENGTH, seen_count + 3);
            send_bytes(1, 1'b1);
         end
         5: begin
            // runs long
            set_reg(REG_MEMBER_LENGTH, seen_count + 1);
            send_bytes(1, 1'b0);
         end
         6: begin
            set_reg(REG_MEMBER_LENGTH, seen_count);
            send_bytes(1, 1'b0);
         end
         default: begin
            set_reg(REG_MEMBER_LENGTH, 32'd0);
            send_bytes(1, 1'b0);
         end
      endcase
      settle();

      // halted: these transactions produce nothing
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_bytes(2, 1'b1);
      settle();

      if (mismatches == 0 && envelope_bytes_due.size() == 0) begin
         $display("gzip_stored_envelope_framer: match");
      end else begin
         $display("gzip_stored_envelope_framer: mismatch");
      end
      $finish;
   end

endmodule
